### rtl/hlkv_pkg.sv
// ----------------------------------------------------------------------------
// Hashed LRU key/value cache package
// Shared constants, operation codes and the command and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package hlkv_pkg;

    localparam int TableDepthDef = 64;
    localparam int KeyBytes      = 8;
    localparam int KeyW          = 64;
    localparam int LenW          = 4;
    localparam int ValW          = 16;
    localparam int StampW        = 32;
    localparam int UsedW         = 7;
    localparam int ActW          = 2;

    localparam logic [KeyW-1:0]   HashStart = 64'd5381;
    localparam int                HashShift = 5;
    localparam logic [StampW-1:0] StampMax  = '1;

    typedef enum logic [ActW-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef struct packed {
        logic accept;
        logic hash_step;
        logic set_home;
        logic mod_step;
        logic advance;
        logic refresh;
        logic scan_init;
        logic scan_chk;
        logic write;
        logic clear;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic is_insert;
        logic is_clear;
        logic hash_done;
        logic mod_last;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic slot_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/hlkv_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one cache operation with its key and value.
// ----------------------------------------------------------------------------
interface hlkv_req_if;
    logic                              valid;
    logic                              ready;
    logic [hlkv_pkg::ActW-1:0]         action;
    logic [hlkv_pkg::KeyW-1:0]         key_bytes;
    logic [hlkv_pkg::LenW-1:0]         key_length;
    logic [hlkv_pkg::ValW-1:0]         store_value;

    modport source (output valid, action, key_bytes, key_length, store_value, input ready);
    modport sink   (input valid, action, key_bytes, key_length, store_value, output ready);
endinterface

### rtl/hlkv_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the hit flag, the found value and the count of used entries.
// ----------------------------------------------------------------------------
interface hlkv_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [hlkv_pkg::ValW-1:0]         found_value;
    logic [hlkv_pkg::UsedW-1:0]        entry_count;

    modport source (output valid, hit, found_value, entry_count, input ready);
    modport sink   (input valid, hit, found_value, entry_count, output ready);
endinterface

### rtl/hlkv_ctrl.sv
// ----------------------------------------------------------------------------
// Cache controller
// One-hot sequencer that walks hashing, reduction, probing, eviction scan,
// slot write and response for one operation at a time.
// ----------------------------------------------------------------------------
module hlkv_ctrl #(
    parameter int TABLE_DEPTH = hlkv_pkg::TableDepthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hlkv_pkg::t_stat i_stat,
    output hlkv_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    input  logic            i_in_valid
);
    import hlkv_pkg::*;

    localparam bit IsPow2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_HASH     = 9'b000000010,
        ST_MOD      = 9'b000000100,
        ST_PROBE_RD = 9'b000001000,
        ST_PROBE_CK = 9'b000010000,
        ST_SCAN_RD  = 9'b000100000,
        ST_SCAN_CK  = 9'b001000000,
        ST_WRITE    = 9'b010000000,
        ST_RESP     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_HASH;
                end
            end
            ST_HASH: begin
                if (i_stat.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_RESP;
                end else if (!i_stat.is_lookup && !i_stat.is_insert) begin
                    n_state = ST_RESP;
                end else if (!i_stat.hash_done) begin
                    o_cmd.hash_step = 1'b1;
                end else if (IsPow2) begin
                    o_cmd.set_home = 1'b1;
                    n_state        = ST_PROBE_RD;
                end else begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                n_state = ST_PROBE_CK;
            end
            ST_PROBE_CK: begin
                if (i_stat.is_lookup) begin
                    if (!i_stat.slot_valid) begin
                        n_state = ST_RESP;
                    end else if (i_stat.key_match) begin
                        o_cmd.refresh = 1'b1;
                        n_state       = ST_RESP;
                    end else if (i_stat.probe_last) begin
                        n_state = ST_RESP;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_PROBE_RD;
                    end
                end else begin
                    if (!i_stat.slot_valid || i_stat.key_match) begin
                        n_state = ST_WRITE;
                    end else if (i_stat.probe_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN_RD;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_PROBE_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CK;
            end
            ST_SCAN_CK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = i_stat.slot_last ? ST_WRITE : ST_SCAN_RD;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_HASH)
        else $error("accept did not start hashing");
    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |=> r_state == ST_RESP && !o_in_ready)
        else $error("write not followed by response");
    a_probe_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PROBE_RD |=> r_state == ST_PROBE_CK)
        else $error("probe read not followed by check");
`endif
endmodule

### rtl/hlkv_dp.sv
// ----------------------------------------------------------------------------
// Cache datapath
// Request registers, hash and remainder units, slot memories, valid bits,
// counters, eviction search and the response register.
// ----------------------------------------------------------------------------
module hlkv_dp #(
    parameter int TABLE_DEPTH = hlkv_pkg::TableDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hlkv_pkg::t_cmd                i_cmd,
    output hlkv_pkg::t_stat               o_stat,
    input  logic [hlkv_pkg::ActW-1:0]     i_action,
    input  logic [hlkv_pkg::KeyW-1:0]     i_key_bytes,
    input  logic [hlkv_pkg::LenW-1:0]     i_key_length,
    input  logic [hlkv_pkg::ValW-1:0]     i_store_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic [hlkv_pkg::ValW-1:0]     o_found_value,
    output logic [hlkv_pkg::UsedW-1:0]    o_entry_count
);
    import hlkv_pkg::*;

    localparam int SlotW  = $clog2(TABLE_DEPTH);
    localparam int CountW = $clog2(TABLE_DEPTH + 1);
    localparam logic [SlotW-1:0]  LastSlot = SlotW'(TABLE_DEPTH - 1);
    localparam logic [SlotW:0]    DepthW   = (SlotW + 1)'(TABLE_DEPTH);
    localparam logic [LenW-1:0]   MaxLen   = LenW'(KeyBytes);

    // Slot memories, read at the current slot with registered data.
    logic [KeyW-1:0]   m_key   [TABLE_DEPTH];
    logic [LenW-1:0]   m_len   [TABLE_DEPTH];
    logic [ValW-1:0]   m_val   [TABLE_DEPTH];
    logic [StampW-1:0] m_stamp [TABLE_DEPTH];

    logic [KeyW-1:0]   r_rd_key;
    logic [LenW-1:0]   r_rd_len;
    logic [ValW-1:0]   r_rd_val;
    logic [StampW-1:0] r_rd_stamp;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [StampW-1:0]      r_counter;
    logic [CountW-1:0]      r_count;

    logic [ActW-1:0]   r_action;
    logic [KeyW-1:0]   r_key;
    logic [LenW-1:0]   r_len;
    logic [ValW-1:0]   r_value;
    logic [KeyW-1:0]   r_hash;
    logic [LenW-1:0]   r_idx;
    logic [SlotW-1:0]  r_rem;
    logic [2:0]        r_mod_idx;
    logic [SlotW-1:0]  r_slot;
    logic [SlotW-1:0]  r_probes;
    logic [SlotW-1:0]  r_best;
    logic [StampW-1:0] r_best_stamp;
    logic              r_hit;
    logic [ValW-1:0]   r_found;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [ValW-1:0]   r_out_found;
    logic [UsedW-1:0]  r_out_used;

    logic [LenW-1:0]   n_len;
    logic [KeyW-1:0]   n_key;
    logic [SlotW-1:0]  w_shift_rem [TABLE_DEPTH];
    logic [SlotW-1:0]  w_byte_rem  [256];
    logic [SlotW:0]    w_rem_sum;
    logic [SlotW-1:0]  n_rem;
    logic [SlotW-1:0]  n_slot_inc;
    logic [SlotW-1:0]  n_best;
    logic [StampW-1:0] n_best_stamp;
    logic [StampW-1:0] n_stamp;
    logic [7:0]        w_byte;
    logic              w_match;

    // Saturate the length and clear bytes beyond it.
    always_comb begin
        n_len = (i_key_length > MaxLen) ? MaxLen : i_key_length;
        for (int b = 0; b < 8; b++) begin
            n_key[b*8 +: 8] = (LenW'(b) < n_len) ? i_key_bytes[b*8 +: 8] : 8'h00;
        end
    end

    // Constant tables for the byte-wise remainder: the partial remainder
    // times 256 and the incoming byte, each reduced by the table depth.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_shift_rem
        assign w_shift_rem[g] = SlotW'((g * 256) % TABLE_DEPTH);
    end
    for (genvar g = 0; g < 256; g++) begin : g_byte_rem
        assign w_byte_rem[g] = SlotW'(g % TABLE_DEPTH);
    end

    assign w_byte     = r_key[{r_idx[2:0], 3'b000} +: 8];
    assign w_rem_sum  = {1'b0, w_shift_rem[r_rem]} + {1'b0, w_byte_rem[r_hash[KeyW-1 -: 8]]};
    assign n_rem      = (w_rem_sum >= DepthW) ? SlotW'(w_rem_sum - DepthW)
                                              : w_rem_sum[SlotW-1:0];
    assign n_slot_inc = (r_slot == LastSlot) ? '0 : r_slot + 1'b1;
    assign n_stamp    = (r_counter == StampMax) ? r_counter : r_counter + 1'b1;
    assign w_match    = (r_rd_len == r_len) && (r_rd_key == r_key);

    // Oldest-entry search keeps the lowest index among equal stamps.
    always_comb begin
        if (r_slot == '0 || r_rd_stamp < r_best_stamp) begin
            n_best       = r_slot;
            n_best_stamp = r_rd_stamp;
        end else begin
            n_best       = r_best;
            n_best_stamp = r_best_stamp;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.is_lookup  = (r_action == ACT_LOOKUP);
        o_stat.is_insert  = (r_action == ACT_INSERT);
        o_stat.is_clear   = (r_action == ACT_CLEAR);
        o_stat.hash_done  = (r_idx == r_len);
        o_stat.mod_last   = (r_mod_idx == 3'd7);
        o_stat.slot_valid = r_valid[r_slot];
        o_stat.key_match  = w_match;
        o_stat.probe_last = (r_probes == LastSlot);
        o_stat.slot_last  = (r_slot == LastSlot);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        r_rd_key   <= m_key[r_slot];
        r_rd_len   <= m_len[r_slot];
        r_rd_val   <= m_val[r_slot];
        r_rd_stamp <= m_stamp[r_slot];
        if (i_cmd.write) begin
            m_key[r_slot] <= r_key;
            m_len[r_slot] <= r_len;
            m_val[r_slot] <= r_value;
        end
        if (i_cmd.write || i_cmd.refresh) begin
            m_stamp[r_slot] <= n_stamp;
        end
    end

    // Operation payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_action;
            r_key     <= n_key;
            r_len     <= n_len;
            r_value   <= i_store_value;
            r_hash    <= HashStart;
            r_idx     <= '0;
            r_rem     <= '0;
            r_mod_idx <= '0;
            r_hit     <= 1'b0;
            r_found   <= '0;
        end
        if (i_cmd.hash_step) begin
            r_hash <= (r_hash << HashShift) + r_hash + KeyW'(w_byte);
            r_idx  <= r_idx + 1'b1;
        end
        if (i_cmd.mod_step) begin
            r_rem     <= n_rem;
            r_hash    <= r_hash << 8;
            r_mod_idx <= r_mod_idx + 1'b1;
            if (r_mod_idx == 3'd7) begin
                r_slot   <= n_rem;
                r_probes <= '0;
            end
        end
        if (i_cmd.set_home) begin
            r_slot   <= r_hash[SlotW-1:0];
            r_probes <= '0;
        end
        if (i_cmd.advance) begin
            r_slot   <= n_slot_inc;
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.refresh) begin
            r_hit   <= 1'b1;
            r_found <= r_rd_val;
        end
        if (i_cmd.scan_init) begin
            r_slot <= '0;
        end
        if (i_cmd.scan_chk) begin
            r_best       <= n_best;
            r_best_stamp <= n_best_stamp;
            r_slot       <= (r_slot == LastSlot) ? n_best : n_slot_inc;
        end
    end

    // Valid bits, access counter and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_count   <= '0;
        end else if (i_cmd.clear) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.write || i_cmd.refresh) begin
                r_counter <= n_stamp;
            end
            if (i_cmd.write) begin
                r_valid[r_slot] <= 1'b1;
                if (!r_valid[r_slot]) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit   <= r_hit;
            r_out_found <= r_found;
            r_out_used  <= UsedW'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_found_value  = r_out_found;
    assign o_entry_count  = r_out_used;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(TABLE_DEPTH))
        else $error("fill count above table depth");
    a_count_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write && !r_valid[r_slot] |=> r_count == $past(r_count) + 1'b1)
        else $error("fill count missed a new entry");
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_count == '0 && r_valid == '0)
        else $error("clear left entries behind");
`endif
endmodule

### rtl/hashed_lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// Hashed LRU key/value cache core
// Fixed-size cache of short string keys with djb2 hashing, linear probing and
// least-recently-used eviction when the table is full.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  i_req     in         action, key_bytes, key_length, store_value
//  o_rsp     out        hit, found_value, entry_count
//
// One operation is in flight at a time. It passes through an accept step, a
// hash step for each key character, a byte-wise remainder over the hash bytes
// when the table depth is not a power of two, the choice of the home slot, a
// memory read and then a compare for each probed slot, a read and a check for
// each slot of the eviction scan on a full table, a write for an insert and
// the response. Clear and the unused code go from the hash state straight to
// the response. Reset is synchronous and active low; it empties the table at
// once through the valid bits. A stalled response waits in the output
// register and holds the sequencer in its response state until it transfers.
//
module hashed_lru_key_value_cache_core #(
    parameter int TABLE_DEPTH = hlkv_pkg::TableDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlkv_req_if.sink   i_req,
    hlkv_rsp_if.source o_rsp
);
    import hlkv_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The sequencer decides each step from the datapath status.
    hlkv_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (i_req.ready),
        .i_in_valid (i_req.valid)
    );

    // The datapath holds the table, the counters and the response register.
    hlkv_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_req.action),
        .i_key_bytes    (i_req.key_bytes),
        .i_key_length   (i_req.key_length),
        .i_store_value  (i_req.store_value),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_hit          (o_rsp.hit),
        .o_found_value  (o_rsp.found_value),
        .o_entry_count  (o_rsp.entry_count)
    );

endmodule

### verif/hlkv_tb_pkg.sv
// ----------------------------------------------------------------------------
// Cache testbench package
// Shared sizes for the cache testbench.
// ----------------------------------------------------------------------------
package hlkv_tb_pkg;

    localparam int Depth = hlkv_pkg::TableDepthDef;

endpackage

### verif/hlkv_cache_checker.sv
// ----------------------------------------------------------------------------
// Cache response checker
// Mirrors the cache contents from the accepted requests and compares every
// response transfer with the predicted hit, value and entry count.
// ----------------------------------------------------------------------------
module hlkv_cache_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hlkv_req_if    i_req,
    hlkv_rsp_if    i_rsp,
    output int     o_fail_count,
    output int     o_pending
);
    import hlkv_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [ValW-1:0]  found_value;
        logic [UsedW-1:0] entry_count;
    } t_answer;

    logic [KeyW-1:0]   tbl_key   [hlkv_tb_pkg::Depth];
    logic [LenW-1:0]   tbl_len   [hlkv_tb_pkg::Depth];
    logic [ValW-1:0]   tbl_val   [hlkv_tb_pkg::Depth];
    logic [StampW-1:0] tbl_stamp [hlkv_tb_pkg::Depth];
    logic              tbl_valid [hlkv_tb_pkg::Depth];
    logic [StampW-1:0] use_clock;
    int                live_count;
    t_answer           answers_due[$];

    function automatic logic [StampW-1:0] tick_clock();
        if (use_clock != StampMax) use_clock = use_clock + 1;
        return use_clock;
    endfunction

    function automatic int home_of(logic [KeyW-1:0] k, int n);
        logic [63:0] h;
        h = 64'd5381;
        for (int i = 0; i < n; i++) h = (h << 5) + h + k[8*i +: 8];
        return int'(h % hlkv_tb_pkg::Depth);
    endfunction

    function automatic void store_at(int s, logic [KeyW-1:0] k, int n, logic [ValW-1:0] v);
        if (!tbl_valid[s]) live_count++;
        tbl_key[s] = k;
        tbl_len[s] = LenW'(n);
        tbl_val[s] = v;
        tbl_stamp[s] = tick_clock();
        tbl_valid[s] = 1'b1;
    endfunction

    function automatic t_answer apply_request(t_action act, logic [KeyW-1:0] raw,
                                              logic [LenW-1:0] raw_len, logic [ValW-1:0] v);
        t_answer a;
        logic [KeyW-1:0] k;
        int n, home, s, victim;
        bit done;
        a = '0;
        n = (raw_len > KeyBytes) ? KeyBytes : int'(raw_len);
        k = (n < 8) ? raw & ((64'd1 << (8 * n)) - 1) : raw;
        done = 0;
        home = home_of(k, n);
        case (act)
            ACT_LOOKUP: begin
                for (int i = 0; i < hlkv_tb_pkg::Depth && !done; i++) begin
                    s = (home + i) % hlkv_tb_pkg::Depth;
                    if (!tbl_valid[s]) done = 1;
                    else if (tbl_len[s] == n && tbl_key[s] == k) begin
                        tbl_stamp[s] = tick_clock();
                        a.hit = 1'b1;
                        a.found_value = tbl_val[s];
                        done = 1;
                    end
                end
            end
            ACT_INSERT: begin
                for (int i = 0; i < hlkv_tb_pkg::Depth && !done; i++) begin
                    s = (home + i) % hlkv_tb_pkg::Depth;
                    if (!tbl_valid[s] || (tbl_len[s] == n && tbl_key[s] == k)) begin
                        store_at(s, k, n, v);
                        done = 1;
                    end
                end
                if (!done) begin
                    // Table is full: the lowest index among the oldest stamps goes.
                    victim = 0;
                    for (int i = 0; i < hlkv_tb_pkg::Depth; i++)
                        if (tbl_stamp[i] < tbl_stamp[victim]) victim = i;
                    store_at(victim, k, n, v);
                end
            end
            ACT_CLEAR: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
                use_clock = '0;
                live_count = 0;
            end
            default: ;
        endcase
        a.entry_count = UsedW'(live_count);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            use_clock = '0;
            live_count = 0;
            answers_due.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (answers_due.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_rsp.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_rsp.hit);
                        errs++;
                    end
                    if (i_rsp.found_value !== want.found_value) begin
                        $error("found_value: expected %0h, got %0h",
                               want.found_value, i_rsp.found_value);
                        errs++;
                    end
                    if (i_rsp.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_rsp.entry_count);
                        errs++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                answers_due.push_back(apply_request(t_action'(i_req.action), i_req.key_bytes,
                                                    i_req.key_length, i_req.store_value));
            o_fail_count <= o_fail_count + errs;
            o_pending <= answers_due.size();
        end
    end

endmodule

### verif/hashed_lru_key_value_cache_core_tb.sv
// ----------------------------------------------------------------------------
// Cache core testbench
// Sends directed and random cache operations through the request channel,
// stalls both channels at random and lets the checker judge every response.
// ----------------------------------------------------------------------------
module hashed_lru_key_value_cache_core_tb;
    import hlkv_pkg::*;

    localparam int RandomCount = 670;
    localparam int CycleLimit  = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   calm = 0;       // set for the final stretch, where nobody idles
    bit   hold_off = 0;   // long receiver stall requested by the stimulus

    hlkv_req_if req_ch ();
    hlkv_rsp_if rsp_ch ();

    hashed_lru_key_value_cache_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    hlkv_cache_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // The watchdog stops a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("hashed_lru_key_value_cache_core test failed");
            $finish;
        end
    end

    // The response side drops ready in short bursts, or for a long stretch on
    // request so the core's output register fills and the request side backs up.
    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
                wait (!hold_off);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                rsp_ch.ready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // A key pool keeps lookups hitting stored entries now and then.
    logic [KeyW-1:0] pool_key [16];
    logic [LenW-1:0] pool_len [16];

    // One request transfer. Valid stays high across back-to-back items.
    task automatic send_op(t_action act, logic [KeyW-1:0] k, logic [LenW-1:0] n,
                           logic [ValW-1:0] v);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.key_bytes   <= k;
        req_ch.key_length  <= n;
        req_ch.store_value <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        int p;
        int pick;
        t_action act;
        logic [KeyW-1:0] k;
        logic [LenW-1:0] n;
        p = $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        act = (pick < 45) ? ACT_LOOKUP : (pick < 92) ? ACT_INSERT :
              (pick < 96) ? ACT_NOP : ACT_CLEAR;
        if ($urandom_range(0, 2) != 0) begin
            // Reuse a pooled key, sometimes with stray high bytes.
            k = pool_key[p];
            n = pool_len[p];
            if ($urandom_range(0, 3) == 0 && n < 8)
                k = k | ({$urandom, $urandom} << (8 * n));
        end else begin
            k = {$urandom, $urandom};
            n = LenW'($urandom_range(0, 15));
        end
        send_op(act, k, n, 16'($urandom));
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = ACT_LOOKUP;
        req_ch.key_bytes = '0;
        req_ch.key_length = '0;
        req_ch.store_value = '0;
        foreach (pool_key[i]) begin
            pool_key[i] = {$urandom, $urandom};
            pool_len[i] = LenW'($urandom_range(0, 8));
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty lookup, empty key, long key saturation, stray bits,
        // length identity, update, nop and clear.
        send_op(ACT_LOOKUP, 64'h0, 4'd0, 16'hFFFF);
        send_op(ACT_INSERT, 64'h0, 4'd0, 16'h1234);
        send_op(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 16'h0);
        send_op(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'hFFFF);
        send_op(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'h0);
        send_op(ACT_INSERT, 64'hDEAD_BEEF_0000_0041, 4'd1, 16'h00AA);
        send_op(ACT_LOOKUP, 64'h0000_0000_0000_0041, 4'd1, 16'h0);
        send_op(ACT_LOOKUP, 64'h0000_0000_0000_0041, 4'd2, 16'h0);
        send_op(ACT_INSERT, 64'h41, 4'd1, 16'h5555);
        send_op(ACT_LOOKUP, 64'h41, 4'd1, 16'h0);
        send_op(ACT_NOP, 64'h41, 4'd1, 16'h0);
        send_op(ACT_CLEAR, 64'h0, 4'd0, 16'h0);
        send_op(ACT_LOOKUP, 64'h41, 4'd1, 16'h0);

        // Fill the table past capacity so eviction by age is exercised, touching
        // the first key now and then to move it out of the oldest spot.
        for (int i = 0; i < 80; i++) begin
            send_op(ACT_INSERT, 64'(i) + 64'h3000, 4'd2, 16'(i));
            if (i % 7 == 3) send_op(ACT_LOOKUP, 64'h3000, 4'd2, 16'h0);
        end
        for (int i = 0; i < 80; i += 9) send_op(ACT_LOOKUP, 64'(i) + 64'h3000, 4'd2, 16'h0);

        // Long receiver stall while requests keep coming.
        hold_off = 1;
        for (int i = 0; i < 20; i++) send_random();
        hold_off = 0;

        for (int i = 0; i < RandomCount; i++) begin
            if (i == RandomCount - 100) calm = 1;
            send_random();
        end
        req_ch.valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("hashed_lru_key_value_cache_core test passed");
        end else begin
            $display("hashed_lru_key_value_cache_core test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/hlkv_pkg.sv
rtl/hlkv_req_if.sv
rtl/hlkv_rsp_if.sv
rtl/hlkv_ctrl.sv
rtl/hlkv_dp.sv
rtl/hashed_lru_key_value_cache_core.sv
verif/hlkv_tb_pkg.sv
verif/hlkv_cache_checker.sv
verif/hashed_lru_key_value_cache_core_tb.sv
